// ===== hdl/tse_pkg.sv =====
// Shared constants, codes, result type and decode helpers for the thumb store unit.
// No dependencies; thumb_store_execute_unit uses this package.
package tse_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    typedef logic [REG_AW-1:0] t_reg_idx;

    localparam t_reg_idx SP_INDEX = t_reg_idx'(13);
    localparam t_reg_idx PC_INDEX = t_reg_idx'(15);
    localparam t_reg_idx RT_LIMIT = t_reg_idx'(13);

    // input opcodes
    localparam logic [1:0] OP_WR_REG = 2'd0;
    localparam logic [1:0] OP_RD_REG = 2'd1;
    localparam logic [1:0] OP_EXEC   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_UNPRED  = 3'd2;
    localparam logic [2:0] KIND_BADADDR = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // instruction forms
    typedef logic [3:0] t_form;
    localparam t_form FORM_NONE     = 4'd0;
    localparam t_form FORM_STR_IMM  = 4'd1;
    localparam t_form FORM_STR_REG  = 4'd2;
    localparam t_form FORM_STR_SP   = 4'd3;
    localparam t_form FORM_STRB_IMM = 4'd4;
    localparam t_form FORM_STR_T4   = 4'd5;
    localparam t_form FORM_STRB_T2  = 4'd6;
    localparam t_form FORM_STRB_T3  = 4'd7;
    localparam t_form FORM_STRD     = 4'd8;
    localparam t_form FORM_STRH_T2  = 4'd9;

    // must-be-one / must-be-zero masks
    localparam logic [31:0] STR_IMM_ONES  = 32'h0000_6000;
    localparam logic [31:0] STR_IMM_ZEROS = 32'hffff_9800;
    localparam logic [31:0] STR_REG_ONES  = 32'h0000_5000;
    localparam logic [31:0] STR_REG_ZEROS = 32'hffff_ae00;
    localparam logic [31:0] STR_SP_ONES   = 32'h0000_9000;
    localparam logic [31:0] STR_SP_ZEROS  = 32'hffff_6800;
    localparam logic [31:0] STRB_IMM_ONES = 32'h0000_7000;
    localparam logic [31:0] STRB_IMM_ZEROS = 32'hffff_8800;
    localparam logic [31:0] STR_T4_ONES   = 32'hf840_0800;
    localparam logic [31:0] STR_T4_ZEROS  = 32'h07b0_0000;
    localparam logic [31:0] STRB_T2_ONES  = 32'hf880_0000;
    localparam logic [31:0] STRB_T2_ZEROS = 32'h0770_0000;
    localparam logic [31:0] STRB_T3_ONES  = 32'hf800_0800;
    localparam logic [31:0] STRB_T3_ZEROS = 32'h07f0_0000;
    localparam logic [31:0] STRD_ONES     = 32'he840_0000;
    localparam logic [31:0] STRD_ZEROS    = 32'h1610_0000;
    localparam logic [31:0] STRH_T2_ONES  = 32'hf8a0_0000;
    localparam logic [31:0] STRH_T2_ZEROS = 32'h0750_0000;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [1:0]  access_size;
        logic [31:0] read_data;
        logic        last;
    } t_result;

    function automatic logic f_match(logic [31:0] w, logic [31:0] ones, logic [31:0] zeros);
        return ((w & ones) == ones) && ((w & zeros) == 32'd0);
    endfunction

    // first matching form wins
    function automatic t_form f_decode(logic [31:0] w);
        t_form form;
        form = FORM_NONE;
        if (f_match(w, STR_IMM_ONES, STR_IMM_ZEROS)) begin
            form = FORM_STR_IMM;
        end else if (f_match(w, STR_REG_ONES, STR_REG_ZEROS)) begin
            form = FORM_STR_REG;
        end else if (f_match(w, STR_SP_ONES, STR_SP_ZEROS)) begin
            form = FORM_STR_SP;
        end else if (f_match(w, STRB_IMM_ONES, STRB_IMM_ZEROS)) begin
            form = FORM_STRB_IMM;
        end else if (f_match(w, STR_T4_ONES, STR_T4_ZEROS)) begin
            form = FORM_STR_T4;
        end else if (f_match(w, STRB_T2_ONES, STRB_T2_ZEROS)) begin
            form = FORM_STRB_T2;
        end else if (f_match(w, STRB_T3_ONES, STRB_T3_ZEROS)) begin
            form = FORM_STRB_T3;
        end else if (f_match(w, STRD_ONES, STRD_ZEROS)) begin
            form = FORM_STRD;
        end else if (f_match(w, STRH_T2_ONES, STRH_T2_ZEROS)) begin
            form = FORM_STRH_T2;
        end
        return form;
    endfunction

    function automatic logic [31:0] f_size_mask(logic [1:0] size, logic [31:0] data);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = {24'd0, data[7:0]};
            SIZE_HALF: m = {16'd0, data[15:0]};
            default:   m = data;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/tse_if.sv =====
// Valid/ready channel interfaces for the thumb store unit: command input and result output.
// Depends on nothing; payload widths follow the block's field list.
interface tse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] instruction;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;

    modport source (output valid, output opcode, output instruction,
                    output reg_index, output reg_value, input ready);
    modport sink   (input valid, input opcode, input instruction,
                    input reg_index, input reg_value, output ready);
endinterface

interface tse_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  access_size;
    logic [31:0] read_data;
    logic        last;

    modport source (output valid, output result_kind, output address, output write_data,
                    output access_size, output read_data, output last, input ready);
    modport sink   (input valid, input result_kind, input address, input write_data,
                    input access_size, input read_data, input last, output ready);
endinterface

// ===== hdl/tse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/thumb_store_execute_unit.sv =====
// Thumb store execute unit: decode, register read, address generation and result output.
// Depends on tse_pkg, tse_if (tse_in_if, tse_out_if) and tse_ram.
// An item passes the input register (r_ex), then its results the output register (r_out).
// Throughput: one item per cycle while o_out.ready allows; STRD holds its second write in
//   the second output slot, so the single result port, one transfer per cycle, sets the rate
//   and the next item with a result waits behind an STRD until that second write has left.
// Reset: synchronous, active low; clears all pipeline valids and the per-register
//   written flags, so every register reads as zero until written. No clearing pass.
module thumb_store_execute_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tse_in_if.sink     i_in,
    tse_out_if.source  o_out
);

    localparam int NPORT = 3;   // base, data, third operand (Rm or Rt2)

    typedef struct packed {
        logic [1:0]        opcode;
        logic [31:0]       instruction;
        tse_pkg::t_form    form;
        tse_pkg::t_reg_idx reg_index;
        logic [31:0]       reg_value;
    } t_ex;

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic r_ex_v;
    t_ex  r_ex;
    logic r_out_v;
    logic r_out2_v;
    tse_pkg::t_result r_out;
    tse_pkg::t_result r_out2;

    logic       in_xfer;
    logic       out_xfer;
    logic       out_space;
    logic       ex_commit;
    logic [1:0] ex_nres;

    assign out_xfer  = r_out_v && o_out.ready;
    // room for a new result set: empty, or draining the last held result
    assign out_space = !r_out_v || (out_xfer && !r_out2_v);
    assign ex_commit = r_ex_v && ((ex_nres == 2'd0) || out_space);
    assign i_in.ready = !r_ex_v || ex_commit;
    assign in_xfer   = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Register file: three RAM copies, one read port each, common write
    // ------------------------------------------------------------------
    logic              wr_en;
    tse_pkg::t_reg_idx wr_addr;
    logic [31:0]       wr_data;

    logic [tse_pkg::REG_COUNT-1:0] r_written;
    tse_pkg::t_reg_idx rd_addr [NPORT];
    logic [31:0]       ram_q   [NPORT];
    logic [NPORT-1:0]  r_hit;
    logic [NPORT-1:0]  r_vld;
    logic [31:0]       r_fwd_data;
    logic [31:0]       opnd    [NPORT];

    tse_pkg::t_form    in_form;
    logic [31:0]       in_w;

    assign in_w    = i_in.instruction;
    assign in_form = tse_pkg::f_decode(in_w);

    // pick read addresses from the incoming word so data lands with the item
    always_comb begin
        rd_addr[0] = in_w[19:16];
        rd_addr[1] = in_w[15:12];
        rd_addr[2] = in_w[11:8];
        if (i_in.opcode == tse_pkg::OP_RD_REG) begin
            rd_addr[0] = i_in.reg_index;
        end else begin
            case (in_form)
                tse_pkg::FORM_STR_IMM, tse_pkg::FORM_STRB_IMM: begin
                    rd_addr[0] = tse_pkg::t_reg_idx'(in_w[5:3]);
                    rd_addr[1] = tse_pkg::t_reg_idx'(in_w[2:0]);
                end
                tse_pkg::FORM_STR_REG: begin
                    rd_addr[0] = tse_pkg::t_reg_idx'(in_w[5:3]);
                    rd_addr[1] = tse_pkg::t_reg_idx'(in_w[2:0]);
                    rd_addr[2] = tse_pkg::t_reg_idx'(in_w[8:6]);
                end
                tse_pkg::FORM_STR_SP: begin
                    rd_addr[0] = tse_pkg::SP_INDEX;
                    rd_addr[1] = tse_pkg::t_reg_idx'(in_w[10:8]);
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < NPORT; k++) begin : g_rf
        tse_ram #(
            .WIDTH (32),
            .DEPTH (tse_pkg::REG_COUNT)
        ) u_rf (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_data),
            .i_rd_en   (in_xfer),
            .i_rd_addr (rd_addr[k]),
            .o_rd_data (ram_q[k])
        );

        // forward a write that lands on the same edge as the read; unwritten reads zero
        assign opnd[k] = r_hit[k] ? r_fwd_data : (r_vld[k] ? ram_q[k] : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (wr_en) begin
            r_written[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_v <= 1'b0;
        end else if (in_xfer) begin
            r_ex_v <= 1'b1;
        end else if (ex_commit) begin
            r_ex_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ex.opcode      <= i_in.opcode;
            r_ex.instruction <= in_w;
            r_ex.form        <= in_form;
            r_ex.reg_index   <= i_in.reg_index;
            r_ex.reg_value   <= i_in.reg_value;
            r_fwd_data       <= wr_data;
            for (int k = 0; k < NPORT; k++) begin
                r_hit[k] <= wr_en && (wr_addr == rd_addr[k]);
                r_vld[k] <= r_written[rd_addr[k]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Execute: offset select, one add/subtract plus +4 for STRD, checks, result build
    // ------------------------------------------------------------------
    logic [31:0]       w;
    tse_pkg::t_reg_idx rt;
    tse_pkg::t_reg_idx rn;
    tse_pkg::t_reg_idx rt2;
    logic [31:0]       base;
    logic [31:0]       offset;
    logic              idx_pre;
    logic              idx_up;
    logic              idx_wb;
    logic [1:0]        size;
    logic [31:0]       moved;
    logic [31:0]       addr;
    logic [31:0]       addr2;
    logic              bad;
    logic [2:0]        bad_kind;
    logic              ex_wr_en;
    tse_pkg::t_reg_idx ex_wr_addr;
    logic [31:0]       ex_wr_data;
    tse_pkg::t_result  ex_res0;
    tse_pkg::t_result  ex_res1;

    assign w    = r_ex.instruction;
    assign rt   = w[15:12];
    assign rn   = w[19:16];
    assign rt2  = w[11:8];
    assign base = opnd[0];

    always_comb begin
        offset  = 32'd0;
        idx_pre = 1'b1;
        idx_up  = 1'b1;
        idx_wb  = 1'b0;
        size    = tse_pkg::SIZE_WORD;
        case (r_ex.form)
            tse_pkg::FORM_STR_IMM:  offset = {25'd0, w[10:6], 2'b00};
            tse_pkg::FORM_STR_REG:  offset = opnd[2];
            tse_pkg::FORM_STR_SP:   offset = {22'd0, w[7:0], 2'b00};
            tse_pkg::FORM_STRB_IMM: begin
                offset = {27'd0, w[10:6]};
                size   = tse_pkg::SIZE_BYTE;
            end
            tse_pkg::FORM_STR_T4, tse_pkg::FORM_STRB_T3: begin
                offset  = {24'd0, w[7:0]};
                idx_pre = w[10];
                idx_up  = w[9];
                idx_wb  = w[8];
                size    = (r_ex.form == tse_pkg::FORM_STR_T4) ? tse_pkg::SIZE_WORD
                                                              : tse_pkg::SIZE_BYTE;
            end
            tse_pkg::FORM_STRB_T2: begin
                offset = {20'd0, w[11:0]};
                size   = tse_pkg::SIZE_BYTE;
            end
            tse_pkg::FORM_STRH_T2: begin
                offset = {20'd0, w[11:0]};
                size   = tse_pkg::SIZE_HALF;
            end
            tse_pkg::FORM_STRD: begin
                offset  = {22'd0, w[7:0], 2'b00};
                idx_pre = w[24];
                idx_up  = w[23];
                idx_wb  = w[21];
            end
            default: begin
            end
        endcase
    end

    assign moved = idx_up ? (base + offset) : (base - offset);
    assign addr  = idx_pre ? moved : base;
    assign addr2 = addr + 32'd4;

    // register-choice and alignment checks per form
    always_comb begin
        bad      = 1'b0;
        bad_kind = tse_pkg::KIND_UNPRED;
        case (r_ex.form)
            tse_pkg::FORM_STR_IMM, tse_pkg::FORM_STR_REG:
                bad = (addr[1:0] != 2'b00);
            tse_pkg::FORM_STR_SP: begin
                bad      = (addr[1:0] != 2'b00);
                bad_kind = tse_pkg::KIND_BADADDR;
            end
            tse_pkg::FORM_STRB_IMM:
                bad = 1'b0;
            tse_pkg::FORM_STR_T4:
                bad = (rt == tse_pkg::PC_INDEX) || (idx_wb && (rn == rt));
            tse_pkg::FORM_STRB_T2:
                bad = (rn == tse_pkg::PC_INDEX) || (rt >= tse_pkg::RT_LIMIT);
            tse_pkg::FORM_STRB_T3:
                bad = (rt == tse_pkg::SP_INDEX) || (rt == tse_pkg::PC_INDEX)
                      || (idx_wb && (rn == rt));
            tse_pkg::FORM_STRH_T2:
                bad = (rt == tse_pkg::SP_INDEX) || (rt == tse_pkg::PC_INDEX);
            tse_pkg::FORM_STRD:
                bad = (!idx_pre && !idx_wb) || (idx_wb && ((rn == rt) || (rn == rt2)))
                      || (rn == tse_pkg::PC_INDEX) || (rt >= tse_pkg::RT_LIMIT)
                      || (rt2 >= tse_pkg::RT_LIMIT);
            default: begin
                bad      = 1'b1;
                bad_kind = tse_pkg::KIND_UNKNOWN;
            end
        endcase
    end

    always_comb begin
        ex_res0    = '0;
        ex_res1    = '0;
        ex_nres    = 2'd0;
        ex_wr_en   = 1'b0;
        ex_wr_addr = r_ex.reg_index;
        ex_wr_data = r_ex.reg_value;
        case (r_ex.opcode)
            tse_pkg::OP_WR_REG: begin
                ex_wr_en = 1'b1;
            end
            tse_pkg::OP_RD_REG: begin
                ex_nres             = 2'd1;
                ex_res0.result_kind = tse_pkg::KIND_READ;
                ex_res0.read_data   = base;
                ex_res0.last        = 1'b1;
            end
            tse_pkg::OP_EXEC: begin
                if (bad) begin
                    ex_nres             = 2'd1;
                    ex_res0.result_kind = bad_kind;
                    ex_res0.address     = (bad_kind == tse_pkg::KIND_BADADDR) ? addr : 32'd0;
                    ex_res0.last        = 1'b1;
                end else begin
                    ex_res0.result_kind = tse_pkg::KIND_WRITE;
                    ex_res0.address     = addr;
                    ex_res0.write_data  = tse_pkg::f_size_mask(size, opnd[1]);
                    ex_res0.access_size = size;
                    ex_wr_en            = idx_wb;
                    ex_wr_addr          = rn;
                    ex_wr_data          = moved;
                    if (r_ex.form == tse_pkg::FORM_STRD) begin
                        ex_nres             = 2'd2;
                        ex_res0.last        = 1'b0;
                        ex_res1.result_kind = tse_pkg::KIND_WRITE;
                        ex_res1.address     = addr2;
                        ex_res1.write_data  = opnd[2];
                        ex_res1.access_size = tse_pkg::SIZE_WORD;
                        ex_res1.last        = 1'b1;
                    end else begin
                        ex_nres      = 2'd1;
                        ex_res0.last = 1'b1;
                    end
                end
            end
            default: begin
                // undefined opcode: drop with no effect
            end
        endcase
    end

    // commit register write only when the item leaves the execute stage
    assign wr_en   = ex_commit && ex_wr_en;
    assign wr_addr = ex_wr_addr;
    assign wr_data = ex_wr_data;

    // ------------------------------------------------------------------
    // Output register, two slots for STRD
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_out2_v <= 1'b0;
        end else if (ex_commit && (ex_nres != 2'd0)) begin
            // load a new result set; any held result is leaving on this edge
            r_out_v  <= 1'b1;
            r_out2_v <= (ex_nres == 2'd2);
        end else if (out_xfer) begin
            if (r_out2_v) begin
                r_out2_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_commit && (ex_nres != 2'd0)) begin
            r_out  <= ex_res0;
            r_out2 <= ex_res1;
        end else if (out_xfer && r_out2_v) begin
            r_out <= r_out2;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.result_kind = r_out.result_kind;
    assign o_out.address     = r_out.address;
    assign o_out.write_data  = r_out.write_data;
    assign o_out.access_size = r_out.access_size;
    assign o_out.read_data   = r_out.read_data;
    assign o_out.last        = r_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_second_slot_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out2_v |-> r_out_v)
        else $error("second result held without a first");

    a_first_of_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out2_v |-> !r_out.last)
        else $error("first of a result pair marked last");

    a_pair_commit_fills_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_commit && (ex_nres == 2'd2)) |=> (r_out_v && r_out2_v))
        else $error("double-write item did not fill both output slots");

    a_strd_base_not_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (r_ex.opcode == tse_pkg::OP_EXEC) && (r_ex.form == tse_pkg::FORM_STRD))
        |-> (wr_addr != tse_pkg::PC_INDEX))
        else $error("STRD write-back to r15");

endmodule
